// ===== hdl/ivde_pkg.sv =====
// Types, sizes and codes shared by the int8 vector distance engine.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps

package ivde_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int ELEM_W    = 8;
    localparam int DIST_W    = 32;
    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int NORM_W    = $clog2(MAX_DIM * 16384 + 1);
    localparam int SUM_W     = 30;
    localparam int PROD_W    = 2 * NORM_W;
    localparam int ROOT_W    = NORM_W;
    localparam int SQREM_W   = ROOT_W + 2;
    localparam int Q_SHIFT   = 30;
    localparam int MAG_W     = SUM_W;
    localparam int DIVD_W    = MAG_W + Q_SHIFT;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int STEP_W    = $clog2(DIVD_W);

    localparam logic [DIVD_W-1:0] Q_ONE = DIVD_W'(1) << Q_SHIFT;

    localparam logic [1:0] METRIC_L2  = 2'd0;
    localparam logic [1:0] METRIC_IP  = 2'd1;
    localparam logic [1:0] METRIC_COS = 2'd2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last;
    } ivde_in_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     overflow;
    } ivde_out_t;

    typedef struct packed {
        logic acc_en;
        logic acc_snap;
        logic out_load_sum;
        logic mul_load;
        logic sqrt_step;
        logic div_step;
        logic out_load_cos;
    } ivde_cmd_t;

    typedef struct packed {
        logic cos_sel;
        logic denom_zero;
    } ivde_status_t;

endpackage

// ===== hdl/ivde_datapath.sv =====
// Datapath: metric register, accumulators, norm multiplier, square root and divider.
// Depends on ivde_pkg; driven by ivde_ctrl through ivde_cmd_t.
`timescale 1ns / 1ps

module ivde_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    input  ivde_pkg::ivde_in_t    s_data,
    input  ivde_pkg::ivde_cmd_t   cmd,
    output ivde_pkg::ivde_status_t status,
    output ivde_pkg::ivde_out_t   m_data
);
    import ivde_pkg::*;

    logic [1:0]              metric_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [NORM_W-1:0]       na_reg;
    logic [NORM_W-1:0]       nb_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    too_long_reg;

    logic [NORM_W-1:0]       snap_na_reg;
    logic [NORM_W-1:0]       snap_nb_reg;
    logic                    snap_over_reg;
    logic                    neg_reg;

    logic [PROD_W-1:0]       sq_n_reg;
    logic [SQREM_W-3:0]      sq_rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [DIVD_W-1:0]       divd_reg;
    logic [DREM_W-2:0]       drem_reg;
    ivde_out_t               out_reg;

    logic signed [ELEM_W:0]     diff;
    logic signed [2*ELEM_W+1:0] sq_diff;
    logic signed [2*ELEM_W-1:0] prod_ab;
    logic signed [2*ELEM_W-1:0] prod_aa;
    logic signed [2*ELEM_W-1:0] prod_bb;
    logic signed [SUM_W-1:0]    contrib;
    logic                       full;
    logic signed [SUM_W-1:0]    sum_fin;
    logic [NORM_W-1:0]          na_fin;
    logic [NORM_W-1:0]          nb_fin;
    logic                       too_long_fin;
    logic [MAG_W-1:0]           mag_fin;

    logic [SQREM_W-1:0]         sq_rem_sh;
    logic [SQREM_W-1:0]         sq_trial;
    logic                       sq_ge;
    logic [DREM_W-1:0]          drem_sh;
    logic                       d_ge;
    logic [Q_SHIFT:0]           q_clamped;
    logic [DIST_W-1:0]          cos_val;

    always_comb begin
        diff    = $signed({s_data.elem_a[ELEM_W-1], s_data.elem_a})
                - $signed({s_data.elem_b[ELEM_W-1], s_data.elem_b});
        sq_diff = diff * diff;
        prod_ab = s_data.elem_a * s_data.elem_b;
        prod_aa = s_data.elem_a * s_data.elem_a;
        prod_bb = s_data.elem_b * s_data.elem_b;
        contrib = (metric_reg == METRIC_L2) ? SUM_W'(sq_diff) : SUM_W'(prod_ab);
        full    = (cnt_reg == CNT_W'(MAX_DIM));
        sum_fin = full ? sum_reg : sum_reg + contrib;
        na_fin  = full ? na_reg : na_reg + NORM_W'($unsigned(prod_aa));
        nb_fin  = full ? nb_reg : nb_reg + NORM_W'($unsigned(prod_bb));
        too_long_fin = too_long_reg | full;
        mag_fin = sum_fin[SUM_W-1] ? MAG_W'(-sum_fin) : MAG_W'(sum_fin);
    end

    always_comb begin
        sq_rem_sh = {sq_rem_reg, sq_n_reg[PROD_W-1 -: 2]};
        sq_trial  = {root_reg, 2'b01};
        sq_ge     = (sq_rem_sh >= sq_trial);
        drem_sh   = {drem_reg, divd_reg[DIVD_W-1]};
        d_ge      = (drem_sh >= {1'b0, root_reg});
        q_clamped = (divd_reg > Q_ONE) ? Q_ONE[Q_SHIFT:0] : divd_reg[Q_SHIFT:0];
        cos_val   = neg_reg ? -DIST_W'(q_clamped) : DIST_W'(q_clamped);
    end

    assign status.cos_sel    = (metric_reg == METRIC_COS);
    assign status.denom_zero = (root_reg == '0);
    assign m_data            = out_reg;

    // Accumulators and metric register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg   <= METRIC_L2;
            sum_reg      <= '0;
            na_reg       <= '0;
            nb_reg       <= '0;
            cnt_reg      <= '0;
            too_long_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                metric_reg <= cfg_wr_data;
            end
            if (cmd.acc_snap) begin
                sum_reg      <= '0;
                na_reg       <= '0;
                nb_reg       <= '0;
                cnt_reg      <= '0;
                too_long_reg <= 1'b0;
            end else if (cmd.acc_en) begin
                sum_reg      <= sum_fin;
                na_reg       <= na_fin;
                nb_reg       <= nb_fin;
                cnt_reg      <= full ? cnt_reg : cnt_reg + CNT_W'(1);
                too_long_reg <= too_long_fin;
            end
        end
    end

    // Snapshot, root, quotient and output register; payload only
    always_ff @(posedge aclk) begin
        if (cmd.acc_snap) begin
            snap_na_reg   <= na_fin;
            snap_nb_reg   <= nb_fin;
            snap_over_reg <= too_long_fin;
            neg_reg       <= sum_fin[SUM_W-1];
            divd_reg      <= {mag_fin, {Q_SHIFT{1'b0}}};
            drem_reg      <= '0;
        end
        if (cmd.mul_load) begin
            sq_n_reg   <= snap_na_reg * snap_nb_reg;
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        if (cmd.sqrt_step) begin
            sq_n_reg <= {sq_n_reg[PROD_W-3:0], 2'b00};
            if (sq_ge) begin
                sq_rem_reg <= (SQREM_W-2)'(sq_rem_sh - sq_trial);
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                sq_rem_reg <= sq_rem_sh[SQREM_W-3:0];
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div_step) begin
            divd_reg <= {divd_reg[DIVD_W-2:0], d_ge};
            if (d_ge) begin
                drem_reg <= (DREM_W-1)'(drem_sh - {1'b0, root_reg});
            end else begin
                drem_reg <= drem_sh[DREM_W-2:0];
            end
        end
        if (cmd.out_load_sum) begin
            out_reg.distance <= DIST_W'(sum_fin);
            out_reg.overflow <= too_long_fin;
        end else if (cmd.out_load_cos) begin
            out_reg.distance <= status.denom_zero ? '0 : $signed(cos_val);
            out_reg.overflow <= snap_over_reg;
        end
    end

endmodule

// ===== hdl/ivde_ctrl.sv =====
// Controller: transfer acceptance, cosine sequencing and result valid.
// Depends on ivde_pkg; drives ivde_datapath through ivde_cmd_t.
`timescale 1ns / 1ps

module ivde_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_last,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  ivde_pkg::ivde_status_t status,
    output ivde_pkg::ivde_cmd_t    cmd
);
    import ivde_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MULT,
        ST_SQRT,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    logic              take;
    logic              snap;

    always_comb begin
        // hold a last transfer while the result slot or the cosine unit is busy
        s_ready = (state_reg == ST_ACCUM) ? (!m_valid_reg || !s_last) : !s_last;
        take    = s_valid && s_ready;
        snap    = take && s_last;
        cmd.acc_en       = take;
        cmd.acc_snap     = snap;
        cmd.out_load_sum = snap && !status.cos_sel;
        cmd.mul_load     = (state_reg == ST_MULT);
        cmd.sqrt_step    = (state_reg == ST_SQRT);
        cmd.div_step     = (state_reg == ST_DIV);
        cmd.out_load_cos = (state_reg == ST_FIN);
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load_sum || cmd.out_load_cos) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_ACCUM: begin
                    if (snap && status.cos_sel) begin
                        state_reg <= ST_MULT;
                    end
                end
                ST_MULT: begin
                    step_reg  <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (step_reg == STEP_W'(ROOT_W - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_DIV: begin
                    if (status.denom_zero || step_reg == STEP_W'(DIVD_W - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_ACCUM;
                end
                default: begin
                    state_reg <= ST_ACCUM;
                end
            endcase
        end
    end

endmodule

// ===== hdl/int8_vector_distance_engine.sv =====
// L2 and inner product results appear in the cycle after the last transfer;
// cosine runs a multiply, 27 root steps, 60 divide steps (fewer when the root is
// zero) and the output load. Throughput: one element pair per cycle;
// a last transfer waits while a result is pending or the cosine unit is busy.
// Reset: synchronous active-low aresetn clears metric, accumulators and the result valid.
`timescale 1ns / 1ps

module int8_vector_distance_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ivde_pkg::ivde_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ivde_pkg::ivde_out_t m_data
);
    import ivde_pkg::*;

    ivde_cmd_t    cmd;
    ivde_status_t status;

    ivde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ivde_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_data      (m_data)
    );

endmodule

// ===== hdl/ivde_checker.sv =====
// Port-level checks for int8_vector_distance_engine, attached by bind.
// Depends on ivde_pkg and the top-level port names.
`timescale 1ns / 1ps

module ivde_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                cfg_wr_en,
    input logic [1:0]          cfg_wr_data,
    input logic                s_valid,
    input logic                s_ready,
    input ivde_pkg::ivde_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input ivde_pkg::ivde_out_t m_data
);
    import ivde_pkg::*;

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    a_payload_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    a_no_last_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !(s_valid && s_ready && s_data.last))
        else $error("last transfer taken while result pending");

    a_distance_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.distance <= 32'sd1073741824)
                 && (m_data.distance >= -32'sd1073741824))
        else $error("distance out of range");

endmodule

bind int8_vector_distance_engine ivde_checker u_checker (.*);
